// ----- rtl/mgr_pkg.sv -----
// Shared types, widths and sequencer codes for the Mahalanobis gate.
package mgr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int WORD_W      = 32;
  localparam int DIAG_W      = 31;
  localparam int L_W         = (DIAG_W + FRAC_BITS + 1) / 2;
  localparam int OFF_W       = 29;
  localparam int ROOT_W      = 32;
  localparam int Y_W         = ROOT_W + 1;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int DIV_NUM_W   = 64;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);
  localparam int ROOT_CNT_W  = $clog2(ROOT_W + 1);
  localparam int RUN_W       = 8;
  localparam int CNT_W       = 32;
  localparam int VERDICT_W   = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_HELD    = 2'd2;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_RUNS      = 1'b1;

  localparam logic [WORD_W-1:0] THRESHOLD_RST = 32'd196608;
  localparam logic [RUN_W-1:0]  RUNS_RST      = 8'd3;

  typedef enum logic [5:0] {
    OP_SQ_E, OP_SUM_E, OP_SQ_N, OP_SUM_N, OP_SQ_U, OP_SUM_U, OP_ROOT_NORM,
    OP_PIV1, OP_ROOT_L11, OP_LD_NE, OP_DIV_L21, OP_LD_UE, OP_DIV_L31,
    OP_SQ_L21, OP_PIV2, OP_ROOT_L22, OP_LD_UN, OP_MUL_L31L21, OP_SUB_L31L21,
    OP_DIV_L32, OP_SQ_L31, OP_SUM_L31, OP_SQ_L32, OP_SUM_L32, OP_PIV3,
    OP_ROOT_L33, OP_LD_RE, OP_DIV_Y1, OP_LD_RN, OP_MUL_L21Y1, OP_SUB_L21Y1,
    OP_DIV_Y2, OP_LD_RU, OP_MUL_L31Y1, OP_SUB_L31Y1, OP_MUL_L32Y2, OP_SUB_L32Y2,
    OP_DIV_Y3, OP_SQ_Y1, OP_SUM_Y1, OP_SQ_Y2, OP_SUM_Y2, OP_SQ_Y3, OP_SUM_Y3,
    OP_ROOT_DIST, OP_DECIDE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT
  } ctrl_state_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic exec;
    logic start;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic fail;
  } status_t;

  function automatic logic op_uses_div(op_e op);
    return op inside {OP_DIV_L21, OP_DIV_L31, OP_DIV_L32, OP_DIV_Y1, OP_DIV_Y2, OP_DIV_Y3};
  endfunction

  function automatic logic op_uses_root(op_e op);
    return op inside {OP_ROOT_NORM, OP_ROOT_L11, OP_ROOT_L22, OP_ROOT_L33, OP_ROOT_DIST};
  endfunction

endpackage

// ----- rtl/mgr_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module mgr_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mgr_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [mgr_pkg::L_W-1:0]            den_i,
  output logic                               done_o,
  output logic [mgr_pkg::DIV_NUM_W-1:0]      quo_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [mgr_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [mgr_pkg::DIV_NUM_W-1:0]     quo_q;
  logic [mgr_pkg::L_W-1:0]           rem_q;
  logic [mgr_pkg::L_W-1:0]           den_q;
  logic [mgr_pkg::L_W:0]             trial;
  logic                              fits;

  assign trial = {rem_q, quo_q[mgr_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mgr_pkg::DIV_CNT_W'(mgr_pkg::DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mgr_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[mgr_pkg::DIV_NUM_W-2:0], fits};
      rem_q <= fits ? mgr_pkg::L_W'(trial - {1'b0, den_q}) : trial[mgr_pkg::L_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/mgr_sqrt.sv -----
// Digit-by-digit floor square root, one result bit per cycle.
module mgr_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mgr_pkg::RAD_W-1:0]       rad_i,
  output logic                            done_o,
  output logic [mgr_pkg::ROOT_W-1:0]      root_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [mgr_pkg::ROOT_CNT_W-1:0]    cnt_q;
  logic [mgr_pkg::RAD_W-1:0]         rad_q;
  logic [mgr_pkg::ROOT_W:0]          rem_q;
  logic [mgr_pkg::ROOT_W-1:0]        root_q;
  logic [mgr_pkg::ROOT_W+2:0]        cur;
  logic [mgr_pkg::ROOT_W+2:0]        trial;
  logic                              fits;

  assign cur   = {rem_q, rad_q[mgr_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mgr_pkg::ROOT_CNT_W'(mgr_pkg::ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mgr_pkg::ROOT_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[mgr_pkg::RAD_W-3:0], 2'b00};
      root_q <= {root_q[mgr_pkg::ROOT_W-2:0], fits};
      rem_q  <= fits ? (mgr_pkg::ROOT_W+1)'(cur - trial) : cur[mgr_pkg::ROOT_W:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/mgr_datapath.sv -----
// Datapath: operand registers, shared multiplier, accumulator, divider, root and gate state.
module mgr_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mgr_pkg::cmd_t                      cmd_i,
  output mgr_pkg::status_t                   status_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [mgr_pkg::WORD_W-1:0]         cfg_wdata_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  res_east_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  res_north_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  res_up_i,
  input  logic [mgr_pkg::DIAG_W-1:0]         s_ee_i,
  input  logic [mgr_pkg::DIAG_W-1:0]         s_nn_i,
  input  logic [mgr_pkg::DIAG_W-1:0]         s_uu_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  s_ne_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  s_ue_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  s_un_i,
  output logic                               accepted_o,
  output logic [mgr_pkg::VERDICT_W-1:0]      verdict_o,
  output logic [mgr_pkg::ROOT_W-1:0]         innovation_norm_o,
  output logic [mgr_pkg::ROOT_W-1:0]         mahal_distance_o,
  output logic                               not_pos_def_o,
  output logic [mgr_pkg::CNT_W-1:0]          accept_total_o,
  output logic [mgr_pkg::CNT_W-1:0]          reject_total_o
);

  logic signed [mgr_pkg::WORD_W-1:0] re_q, rn_q, ru_q, sne_q, sue_q, sun_q;
  logic [mgr_pkg::DIAG_W-1:0]        see_q, snn_q, suu_q;
  logic [mgr_pkg::L_W-1:0]           l11_q, l22_q, l33_q;
  logic signed [mgr_pkg::OFF_W-1:0]  l21_q, l31_q, l32_q;
  logic signed [mgr_pkg::Y_W-1:0]    y1_q, y2_q, y3_q;
  logic signed [mgr_pkg::ACC_W-1:0]  acc_q, acc_d, acc_mag, acc_sum;
  logic signed [mgr_pkg::ACC_W-1:0]  piv_base, piv_sub, piv_val;
  logic                              piv_bad, sum_ovf;
  logic signed [mgr_pkg::PROD_W-1:0] prod_q;
  logic signed [mgr_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [mgr_pkg::ROOT_W-1:0]        norm_q, dist_q;
  logic                              npd_q, npd_d, sat_q, sat_d;
  logic [mgr_pkg::WORD_W-1:0]        thr_q;
  logic [mgr_pkg::RUN_W-1:0]         runs_q;
  logic                              armed_q;
  logic [mgr_pkg::RUN_W-1:0]         run_q, run_inc, need;
  logic [mgr_pkg::CNT_W-1:0]         acc_cnt_q, rej_cnt_q;

  logic [mgr_pkg::L_W-1:0]           div_den;
  logic                              div_start, div_done, div_neg;
  logic [mgr_pkg::DIV_NUM_W-1:0]     div_quo;
  logic [mgr_pkg::OFF_W-2:0]         off_mag;
  logic signed [mgr_pkg::OFF_W-1:0]  off_val;
  logic signed [mgr_pkg::Y_W-1:0]    y_val;
  logic                              y_over;
  logic                              root_start, root_done;
  logic [mgr_pkg::ROOT_W-1:0]        root_val;
  logic                              fail, outside;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      mgr_pkg::OP_SQ_E:       begin mul_a = mgr_pkg::MUL_W'(re_q);  mul_b = mgr_pkg::MUL_W'(re_q);  end
      mgr_pkg::OP_SQ_N:       begin mul_a = mgr_pkg::MUL_W'(rn_q);  mul_b = mgr_pkg::MUL_W'(rn_q);  end
      mgr_pkg::OP_SQ_U:       begin mul_a = mgr_pkg::MUL_W'(ru_q);  mul_b = mgr_pkg::MUL_W'(ru_q);  end
      mgr_pkg::OP_SQ_L21:     begin mul_a = mgr_pkg::MUL_W'(l21_q); mul_b = mgr_pkg::MUL_W'(l21_q); end
      mgr_pkg::OP_MUL_L31L21: begin mul_a = mgr_pkg::MUL_W'(l31_q); mul_b = mgr_pkg::MUL_W'(l21_q); end
      mgr_pkg::OP_SQ_L31:     begin mul_a = mgr_pkg::MUL_W'(l31_q); mul_b = mgr_pkg::MUL_W'(l31_q); end
      mgr_pkg::OP_SQ_L32:     begin mul_a = mgr_pkg::MUL_W'(l32_q); mul_b = mgr_pkg::MUL_W'(l32_q); end
      mgr_pkg::OP_MUL_L21Y1:  begin mul_a = mgr_pkg::MUL_W'(l21_q); mul_b = y1_q; end
      mgr_pkg::OP_MUL_L31Y1:  begin mul_a = mgr_pkg::MUL_W'(l31_q); mul_b = y1_q; end
      mgr_pkg::OP_MUL_L32Y2:  begin mul_a = mgr_pkg::MUL_W'(l32_q); mul_b = y2_q; end
      mgr_pkg::OP_SQ_Y1:      begin mul_a = y1_q; mul_b = y1_q; end
      mgr_pkg::OP_SQ_Y2:      begin mul_a = y2_q; mul_b = y2_q; end
      mgr_pkg::OP_SQ_Y3:      begin mul_a = y3_q; mul_b = y3_q; end
      default: ;
    endcase
  end

  // pivot: diagonal minus scaled sum of squares
  always_comb begin
    if (cmd_i.op == mgr_pkg::OP_PIV3) begin
      piv_base = mgr_pkg::ACC_W'(suu_q);
      piv_sub  = acc_q >>> mgr_pkg::FRAC_BITS;
    end else begin
      piv_base = mgr_pkg::ACC_W'(snn_q);
      piv_sub  = mgr_pkg::ACC_W'(prod_q >>> mgr_pkg::FRAC_BITS);
    end
  end

  assign piv_val = piv_base - piv_sub;
  assign piv_bad = piv_val[mgr_pkg::ACC_W-1] | (piv_val == '0);
  assign acc_sum = acc_q + mgr_pkg::ACC_W'(prod_q);
  assign sum_ovf = |acc_sum[mgr_pkg::ACC_W-1:mgr_pkg::RAD_W];

  // divider operands and result shaping
  assign acc_mag   = acc_q[mgr_pkg::ACC_W-1] ? -acc_q : acc_q;
  assign div_neg   = acc_q[mgr_pkg::ACC_W-1];
  assign div_start = cmd_i.start & mgr_pkg::op_uses_div(cmd_i.op);

  always_comb begin
    case (cmd_i.op)
      mgr_pkg::OP_DIV_L32, mgr_pkg::OP_DIV_Y2: div_den = l22_q;
      mgr_pkg::OP_DIV_Y3:                      div_den = l33_q;
      default:                                 div_den = l11_q;
    endcase
  end

  assign off_mag = (|div_quo[mgr_pkg::DIV_NUM_W-1:mgr_pkg::OFF_W-1]) ? '1 :
                   div_quo[mgr_pkg::OFF_W-2:0];
  assign off_val = div_neg ? -mgr_pkg::OFF_W'(off_mag) : mgr_pkg::OFF_W'(off_mag);
  assign y_over  = |div_quo[mgr_pkg::DIV_NUM_W-1:mgr_pkg::ROOT_W];
  assign y_val   = div_neg ? -mgr_pkg::Y_W'(div_quo[mgr_pkg::ROOT_W-1:0]) :
                   mgr_pkg::Y_W'(div_quo[mgr_pkg::ROOT_W-1:0]);

  assign root_start = cmd_i.start & mgr_pkg::op_uses_root(cmd_i.op);

  mgr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_mag[mgr_pkg::DIV_NUM_W-1:0]),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  mgr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (acc_q[mgr_pkg::RAD_W-1:0]),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  // accumulator and failure flags
  always_comb begin
    acc_d = acc_q;
    npd_d = npd_q;
    sat_d = sat_q;
    if (cmd_i.load) begin
      npd_d = 1'b0;
      sat_d = 1'b0;
    end else if (cmd_i.exec) begin
      case (cmd_i.op)
        mgr_pkg::OP_SUM_E, mgr_pkg::OP_SUM_L31, mgr_pkg::OP_SUM_Y1:
          acc_d = mgr_pkg::ACC_W'(prod_q);
        mgr_pkg::OP_SUM_N, mgr_pkg::OP_SUM_U, mgr_pkg::OP_SUM_L32, mgr_pkg::OP_SUM_Y2:
          acc_d = acc_sum;
        mgr_pkg::OP_SUM_Y3: begin
          acc_d = acc_sum;
          if (sum_ovf) sat_d = 1'b1;
        end
        mgr_pkg::OP_SUB_L31L21, mgr_pkg::OP_SUB_L21Y1, mgr_pkg::OP_SUB_L31Y1,
        mgr_pkg::OP_SUB_L32Y2:
          acc_d = acc_q - mgr_pkg::ACC_W'(prod_q);
        mgr_pkg::OP_PIV1: begin
          acc_d = mgr_pkg::ACC_W'(see_q) << mgr_pkg::FRAC_BITS;
          if (see_q == '0) npd_d = 1'b1;
        end
        mgr_pkg::OP_PIV2, mgr_pkg::OP_PIV3: begin
          acc_d = piv_val <<< mgr_pkg::FRAC_BITS;
          if (piv_bad) npd_d = 1'b1;
        end
        mgr_pkg::OP_LD_NE: acc_d = mgr_pkg::ACC_W'(sne_q) <<< mgr_pkg::FRAC_BITS;
        mgr_pkg::OP_LD_UE: acc_d = mgr_pkg::ACC_W'(sue_q) <<< mgr_pkg::FRAC_BITS;
        mgr_pkg::OP_LD_UN: acc_d = mgr_pkg::ACC_W'(sun_q) <<< mgr_pkg::FRAC_BITS;
        mgr_pkg::OP_LD_RE: acc_d = mgr_pkg::ACC_W'(re_q) <<< mgr_pkg::FRAC_BITS;
        mgr_pkg::OP_LD_RN: acc_d = mgr_pkg::ACC_W'(rn_q) <<< mgr_pkg::FRAC_BITS;
        mgr_pkg::OP_LD_RU: acc_d = mgr_pkg::ACC_W'(ru_q) <<< mgr_pkg::FRAC_BITS;
        default: ;
      endcase
    end else if (div_done && y_over &&
                 (cmd_i.op == mgr_pkg::OP_DIV_Y1 || cmd_i.op == mgr_pkg::OP_DIV_Y2 ||
                  cmd_i.op == mgr_pkg::OP_DIV_Y3)) begin
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      re_q  <= res_east_i;
      rn_q  <= res_north_i;
      ru_q  <= res_up_i;
      see_q <= s_ee_i;
      snn_q <= s_nn_i;
      suu_q <= s_uu_i;
      sne_q <= s_ne_i;
      sue_q <= s_ue_i;
      sun_q <= s_un_i;
    end
    acc_q  <= acc_d;
    prod_q <= mul_a * mul_b;
    if (div_done) begin
      case (cmd_i.op)
        mgr_pkg::OP_DIV_L21: l21_q <= off_val;
        mgr_pkg::OP_DIV_L31: l31_q <= off_val;
        mgr_pkg::OP_DIV_L32: l32_q <= off_val;
        mgr_pkg::OP_DIV_Y1:  y1_q  <= y_val;
        mgr_pkg::OP_DIV_Y2:  y2_q  <= y_val;
        mgr_pkg::OP_DIV_Y3:  y3_q  <= y_val;
        default: ;
      endcase
    end
    if (root_done) begin
      case (cmd_i.op)
        mgr_pkg::OP_ROOT_NORM: norm_q <= root_val;
        mgr_pkg::OP_ROOT_L11:  l11_q  <= root_val[mgr_pkg::L_W-1:0];
        mgr_pkg::OP_ROOT_L22:  l22_q  <= root_val[mgr_pkg::L_W-1:0];
        mgr_pkg::OP_ROOT_L33:  l33_q  <= root_val[mgr_pkg::L_W-1:0];
        mgr_pkg::OP_ROOT_DIST: dist_q <= root_val;
        default: ;
      endcase
    end
  end

  // gate decision
  assign fail    = npd_q | sat_q;
  assign outside = fail | (dist_q > thr_q);
  assign need    = (runs_q == '0) ? mgr_pkg::RUN_W'(1) : runs_q;
  assign run_inc = (run_q == '1) ? run_q : run_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npd_q     <= 1'b0;
      sat_q     <= 1'b0;
      thr_q     <= mgr_pkg::THRESHOLD_RST;
      runs_q    <= mgr_pkg::RUNS_RST;
      armed_q   <= 1'b0;
      run_q     <= '0;
      acc_cnt_q <= '0;
      rej_cnt_q <= '0;
    end else begin
      npd_q <= npd_d;
      sat_q <= sat_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == mgr_pkg::CFG_THRESHOLD) thr_q <= cfg_wdata_i;
        if (cfg_idx_i == mgr_pkg::CFG_RUNS) runs_q <= cfg_wdata_i[mgr_pkg::RUN_W-1:0];
      end
      if (cmd_i.decide) begin
        if (outside) begin
          armed_q   <= 1'b0;
          run_q     <= '0;
          rej_cnt_q <= rej_cnt_q + 1'b1;
        end else if (armed_q) begin
          acc_cnt_q <= acc_cnt_q + 1'b1;
        end else begin
          run_q <= run_inc;
          if (run_inc >= need) begin
            armed_q   <= 1'b1;
            acc_cnt_q <= acc_cnt_q + 1'b1;
          end else begin
            rej_cnt_q <= rej_cnt_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      innovation_norm_o <= norm_q;
      mahal_distance_o  <= fail ? '1 : dist_q;
      not_pos_def_o     <= npd_q;
      if (outside) begin
        accepted_o     <= 1'b0;
        verdict_o      <= mgr_pkg::VERDICT_OUTSIDE;
        accept_total_o <= acc_cnt_q;
        reject_total_o <= rej_cnt_q + 1'b1;
      end else if (armed_q || (run_inc >= need)) begin
        accepted_o     <= 1'b1;
        verdict_o      <= mgr_pkg::VERDICT_ACCEPT;
        accept_total_o <= acc_cnt_q + 1'b1;
        reject_total_o <= rej_cnt_q;
      end else begin
        accepted_o     <= 1'b0;
        verdict_o      <= mgr_pkg::VERDICT_HELD;
        accept_total_o <= acc_cnt_q;
        reject_total_o <= rej_cnt_q + 1'b1;
      end
    end
  end

  assign status_o.unit_done = div_done | root_done;
  assign status_o.fail      = fail;

endmodule

// ----- rtl/mgr_ctrl.sv -----
// Controller: step sequencer and handshake control for the gate.
module mgr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mgr_pkg::status_t   status_i,
  output mgr_pkg::cmd_t      cmd_o
);

  mgr_pkg::ctrl_state_e state_q, state_d;
  mgr_pkg::op_e         pc_q, pc_d, op_now;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mgr_pkg::ST_IDLE;
      pc_q        <= mgr_pkg::OP_SQ_E;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    in_ready_o    = 1'b0;
    op_now        = status_i.fail ? mgr_pkg::OP_DECIDE : pc_q;
    cmd_o.op      = pc_q;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.decide  = 1'b0;
    case (state_q)
      mgr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = mgr_pkg::OP_SQ_E;
          state_d    = mgr_pkg::ST_EXEC;
        end
      end
      mgr_pkg::ST_EXEC: begin
        cmd_o.op   = op_now;
        cmd_o.exec = 1'b1;
        if (op_now == mgr_pkg::OP_DECIDE) begin
          pc_d = mgr_pkg::OP_DECIDE;
          // result register free or draining this cycle
          if (!out_valid_q || out_ready_i) begin
            cmd_o.decide = 1'b1;
            out_valid_d  = 1'b1;
            state_d      = mgr_pkg::ST_IDLE;
          end
        end else if (mgr_pkg::op_uses_div(op_now) || mgr_pkg::op_uses_root(op_now)) begin
          cmd_o.start = 1'b1;
          state_d     = mgr_pkg::ST_WAIT;
        end else begin
          pc_d = mgr_pkg::op_e'(pc_q + 6'd1);
        end
      end
      mgr_pkg::ST_WAIT: begin
        if (status_i.unit_done) begin
          pc_d    = mgr_pkg::op_e'(pc_q + 6'd1);
          state_d = mgr_pkg::ST_EXEC;
        end
      end
      default: state_d = mgr_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/mahalanobis_gate_reacquire_top.sv -----
// Run time per fix is set by six bit-serial divisions and five bit-serial square
//   roots; a failed pivot or saturated solve ends early.
// Throughput: one fix at a time; the next fix is taken while a result awaits transfer.
// Reset (async, active low): gate unarmed, run and counters zero, threshold 3.0,
//   reacquire count 3, no result pending.
module mahalanobis_gate_reacquire_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [mgr_pkg::WORD_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mgr_pkg::WORD_W-1:0]  res_east_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  res_north_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  res_up_i,
  input  logic [mgr_pkg::DIAG_W-1:0]         s_ee_i,
  input  logic [mgr_pkg::DIAG_W-1:0]         s_nn_i,
  input  logic [mgr_pkg::DIAG_W-1:0]         s_uu_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  s_ne_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  s_ue_i,
  input  logic signed [mgr_pkg::WORD_W-1:0]  s_un_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic [mgr_pkg::VERDICT_W-1:0]      verdict_o,
  output logic [mgr_pkg::ROOT_W-1:0]         innovation_norm_o,
  output logic [mgr_pkg::ROOT_W-1:0]         mahal_distance_o,
  output logic                               not_pos_def_o,
  output logic [mgr_pkg::CNT_W-1:0]          accept_total_o,
  output logic [mgr_pkg::CNT_W-1:0]          reject_total_o
);

  mgr_pkg::cmd_t    cmd;
  mgr_pkg::status_t status;

  mgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mgr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .res_east_i        (res_east_i),
    .res_north_i       (res_north_i),
    .res_up_i          (res_up_i),
    .s_ee_i            (s_ee_i),
    .s_nn_i            (s_nn_i),
    .s_uu_i            (s_uu_i),
    .s_ne_i            (s_ne_i),
    .s_ue_i            (s_ue_i),
    .s_un_i            (s_un_i),
    .accepted_o        (accepted_o),
    .verdict_o         (verdict_o),
    .innovation_norm_o (innovation_norm_o),
    .mahal_distance_o  (mahal_distance_o),
    .not_pos_def_o     (not_pos_def_o),
    .accept_total_o    (accept_total_o),
    .reject_total_o    (reject_total_o)
  );

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a fix is in work");

  a_npd_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_pos_def_o |-> (&mahal_distance_o) && !accepted_o)
    else $error("failed factorization without saturated distance");

  a_accept_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (verdict_o == mgr_pkg::VERDICT_ACCEPT)))
    else $error("accepted flag disagrees with verdict");
`endif

endmodule

// ----- dv/tb_mahalanobis_gate_reacquire_top.sv -----
// Testbench for the Mahalanobis gate: directed and random fixes checked against a predictor.
`timescale 1ns / 1ps

module tb_mahalanobis_gate_reacquire_top;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 700;

  typedef struct packed {
    logic signed [mgr_pkg::WORD_W-1:0] re, rn, ru;
    logic [mgr_pkg::DIAG_W-1:0]        ee, nn, uu;
    logic signed [mgr_pkg::WORD_W-1:0] ne, ue, un;
  } fix_t;

  typedef struct packed {
    logic                          accepted;
    logic [mgr_pkg::VERDICT_W-1:0] verdict;
    logic [mgr_pkg::ROOT_W-1:0]    norm;
    logic [mgr_pkg::ROOT_W-1:0]    mdist;
    logic                          npd;
    logic [mgr_pkg::CNT_W-1:0]     acc_tot;
    logic [mgr_pkg::CNT_W-1:0]     rej_tot;
  } verdict_rec_t;

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [mgr_pkg::WORD_W-1:0] cfg_wdata;
  logic in_valid, in_ready;
  fix_t fix_drv;
  logic out_valid, out_ready;
  logic accepted_o;
  logic [mgr_pkg::VERDICT_W-1:0] verdict_o;
  logic [mgr_pkg::ROOT_W-1:0] norm_o, dist_o;
  logic npd_o;
  logic [mgr_pkg::CNT_W-1:0] acc_tot_o, rej_tot_o;

  verdict_rec_t pending_verdicts[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int rx_wait = 0;

  // gate model state
  logic [mgr_pkg::WORD_W-1:0] m_threshold;
  logic [mgr_pkg::RUN_W-1:0]  m_runs;
  logic                       m_armed;
  logic [mgr_pkg::RUN_W-1:0]  m_run;
  logic [mgr_pkg::CNT_W-1:0]  m_acc, m_rej;

  mahalanobis_gate_reacquire_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .res_east_i(fix_drv.re), .res_north_i(fix_drv.rn), .res_up_i(fix_drv.ru),
    .s_ee_i(fix_drv.ee), .s_nn_i(fix_drv.nn), .s_uu_i(fix_drv.uu),
    .s_ne_i(fix_drv.ne), .s_ue_i(fix_drv.ue), .s_un_i(fix_drv.un),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .accepted_o(accepted_o), .verdict_o(verdict_o),
    .innovation_norm_o(norm_o), .mahal_distance_o(dist_o),
    .not_pos_def_o(npd_o), .accept_total_o(acc_tot_o), .reject_total_o(rej_tot_o)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint clamp_off(longint x);
    longint lim;
    lim = (longint'(1) << 28) - 1;
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // 0 ok, 1 not positive definite, 2 saturated
  function automatic int solve_distance(fix_t f, output logic [mgr_pkg::ROOT_W-1:0] dval);
    longint one, l11, l21, l31, l22, l32, l33, d2, d3, y1, y2, y3, ee;
    longint unsigned q1, q2, q3;
    logic [64:0] sum;
    one = longint'(1) << mgr_pkg::FRAC_BITS;
    dval = '1;
    ee = longint'(f.ee);
    if (ee <= 0) return 1;
    l11 = longint'(sqrt_floor(longint'(ee) << mgr_pkg::FRAC_BITS));
    l21 = clamp_off((longint'(f.ne) * one) / l11);
    l31 = clamp_off((longint'(f.ue) * one) / l11);
    d2 = longint'(f.nn) - (l21 * l21) / one;
    if (d2 <= 0) return 1;
    l22 = longint'(sqrt_floor(d2 << mgr_pkg::FRAC_BITS));
    l32 = clamp_off((longint'(f.un) * one - l31 * l21) / l22);
    d3 = longint'(f.uu) - (l31 * l31 + l32 * l32) / one;
    if (d3 <= 0) return 1;
    l33 = longint'(sqrt_floor(d3 << mgr_pkg::FRAC_BITS));
    y1 = (longint'(f.re) * one) / l11;
    if (mag(y1) >= 64'h1_0000_0000) return 2;
    y2 = (longint'(f.rn) * one - l21 * y1) / l22;
    if (mag(y2) >= 64'h1_0000_0000) return 2;
    y3 = (longint'(f.ru) * one - l31 * y1 - l32 * y2) / l33;
    if (mag(y3) >= 64'h1_0000_0000) return 2;
    q1 = mag(y1) * mag(y1);
    q2 = mag(y2) * mag(y2);
    q3 = mag(y3) * mag(y3);
    sum = {1'b0, q1} + {1'b0, q2};
    if (sum[64]) return 2;
    sum = {1'b0, sum[63:0]} + {1'b0, q3};
    if (sum[64]) return 2;
    dval = mgr_pkg::ROOT_W'(sqrt_floor(sum[63:0]));
    return 0;
  endfunction

  task automatic predict_verdict(input fix_t f);
    verdict_rec_t r;
    longint unsigned sq;
    logic [mgr_pkg::ROOT_W-1:0] dval;
    logic [mgr_pkg::RUN_W-1:0] need;
    int rc;
    r = '0;
    sq = mag(f.re) * mag(f.re) + mag(f.rn) * mag(f.rn) + mag(f.ru) * mag(f.ru);
    r.norm = mgr_pkg::ROOT_W'(sqrt_floor(sq));
    rc = solve_distance(f, dval);
    r.mdist = (rc != 0) ? '1 : dval;
    r.npd = (rc == 1);
    if (rc != 0 || r.mdist > m_threshold) begin
      m_armed = 1'b0;
      m_run = '0;
      m_rej++;
      r.verdict = mgr_pkg::VERDICT_OUTSIDE;
    end else if (m_armed) begin
      m_acc++;
      r.accepted = 1'b1;
      r.verdict = mgr_pkg::VERDICT_ACCEPT;
    end else begin
      if (m_run != 8'hFF) m_run++;
      need = (m_runs == 0) ? 8'd1 : m_runs;
      if (m_run >= need) begin
        m_armed = 1'b1;
        m_acc++;
        r.accepted = 1'b1;
        r.verdict = mgr_pkg::VERDICT_ACCEPT;
      end else begin
        m_rej++;
        r.verdict = mgr_pkg::VERDICT_HELD;
      end
    end
    r.acc_tot = m_acc;
    r.rej_tot = m_rej;
    pending_verdicts.insert(pending_verdicts.size(), r);
  endtask

  task automatic send_fix(input fix_t f);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    fix_drv <= f;
    do @(posedge clk); while (!in_ready);
    predict_verdict(f);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [mgr_pkg::WORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == mgr_pkg::CFG_THRESHOLD) m_threshold = val;
    else m_runs = val[mgr_pkg::RUN_W-1:0];
  endtask

  function automatic fix_t noise_fix();
    fix_t f;
    f.re = $urandom; f.rn = $urandom; f.ru = $urandom;
    f.ee = mgr_pkg::DIAG_W'($urandom);
    f.nn = mgr_pkg::DIAG_W'($urandom);
    f.uu = mgr_pkg::DIAG_W'($urandom);
    f.ne = $urandom; f.ue = $urandom; f.un = $urandom;
    return f;
  endfunction

  function automatic logic signed [mgr_pkg::WORD_W-1:0] spread(longint unsigned span);
    longint v;
    v = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
    return mgr_pkg::WORD_W'(v);
  endfunction

  // positive definite by diagonal dominance, residuals near the gate edge
  function automatic fix_t good_fix();
    fix_t f;
    longint unsigned lim, sig;
    int shift;
    shift = $urandom_range(0, 14);
    f.ee = mgr_pkg::DIAG_W'((longint'($urandom_range(1, 4096)) << shift) +
                            $urandom_range(1, 65535));
    f.nn = mgr_pkg::DIAG_W'((longint'($urandom_range(1, 4096)) << shift) +
                            $urandom_range(1, 65535));
    f.uu = mgr_pkg::DIAG_W'((longint'($urandom_range(1, 4096)) << shift) +
                            $urandom_range(1, 65535));
    lim = f.ee;
    if (f.nn < lim) lim = f.nn;
    if (f.uu < lim) lim = f.uu;
    lim = lim / 4;
    f.ne = spread(lim); f.ue = spread(lim); f.un = spread(lim);
    sig = sqrt_floor(longint'(lim) << mgr_pkg::FRAC_BITS);
    f.re = spread(sig * 3); f.rn = spread(sig * 3); f.ru = spread(sig * 3);
    return f;
  endfunction

  function automatic fix_t quiet_fix();
    fix_t f;
    f = good_fix();
    f.re = f.re >>> 4; f.rn = f.rn >>> 4; f.ru = f.ru >>> 4;
    return f;
  endfunction

  task automatic test_directed;
    fix_t f;
    f = '0; f.ee = 31'h10000; f.nn = 31'h10000; f.uu = 31'h10000;
    repeat (4) send_fix(f);
    f.re = 32'sh7FFFFFFF; f.rn = 32'sh80000000; f.ru = 32'sh7FFFFFFF;
    send_fix(f);
    f.re = 32'sh80000000; f.rn = 32'sh80000000; f.ru = 32'sh80000000;
    f.ee = '1; f.nn = '1; f.uu = '1;
    send_fix(f);
    f = '0; send_fix(f);
    f.ee = 31'h10000; f.nn = 31'h10000; f.uu = 31'h10000; f.ne = 32'sh10000;
    send_fix(f);
    f.ne = 0; f.ue = 32'sh10000; f.un = 32'sh10000; send_fix(f);
    f.ne = 32'sh7FFFFFFF; f.ue = 0; f.un = 0; f.ee = 31'd1; send_fix(f);
    f.ne = 32'sh80000000; f.ue = 32'sh80000000; f.un = 32'sh7FFFFFFF; send_fix(f);
    f = '0; f.ee = 31'd1; f.nn = 31'd1; f.uu = 31'd1;
    f.re = 32'sh7FFFFFFF; send_fix(f);
    f.re = 0; f.ru = 32'sh80000000; send_fix(f);
    f = '0; f.ee = '1; f.nn = '1; f.uu = '1; f.re = 32'sh30000; send_fix(f);
    f.re = 32'sh2FFFF; send_fix(f);
    f.re = 0; f.ne = 32'sh7FFFFFFF; f.ue = 32'sh80000001; f.un = 32'sh7FFFFFFF;
    send_fix(f);
    repeat (6) send_fix(quiet_fix());
    drain();
  endtask

  task automatic test_run_saturation;
    write_reg(mgr_pkg::CFG_RUNS, 8'd255);
    write_reg(mgr_pkg::CFG_THRESHOLD, 32'hFFFFFFFF);
    repeat (262) send_fix(quiet_fix());
    drain();
  endtask

  task automatic test_config_sweep;
    logic [mgr_pkg::WORD_W-1:0] thr[5];
    logic [mgr_pkg::RUN_W-1:0] runs[5];
    thr = '{32'd0, 32'hFFFFFFFF, 32'h30000, 32'h18000, 32'hFFFFFFFE};
    runs = '{8'd0, 8'd1, 8'd3, 8'd255, 8'd7};
    for (int i = 0; i < 5; i++) begin
      write_reg(mgr_pkg::CFG_THRESHOLD, thr[i]);
      write_reg(mgr_pkg::CFG_RUNS, runs[i]);
      repeat (40) send_fix(($urandom_range(0, 3) == 0) ? noise_fix() : good_fix());
      drain();
    end
  endtask

  task automatic test_random;
    fix_t f;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(mgr_pkg::CFG_THRESHOLD,
                (ph == 3) ? $urandom : $urandom_range(32'h10000, 32'h40000));
      write_reg(mgr_pkg::CFG_RUNS, $urandom_range(0, 6));
      for (int i = 0; i < 210; i++) begin
        case ($urandom_range(0, 9))
          0, 1:    f = noise_fix();
          2, 3, 4: f = quiet_fix();
          default: f = good_fix();
        endcase
        send_fix(f);
        if (i == 100) drain();
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        verdict_rec_t e;
        e = pending_verdicts.pop_front();
        if (e != {accepted_o, verdict_o, norm_o, dist_o, npd_o, acc_tot_o, rej_tot_o}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp acc=%0b v=%0d n=%h d=%h npd=%0b at=%0d rt=%0d",
                     e.accepted, e.verdict, e.norm, e.mdist, e.npd, e.acc_tot, e.rej_tot);
            $display("          got acc=%0b v=%0d n=%h d=%h npd=%0b at=%0d rt=%0d",
                     accepted_o, verdict_o, norm_o, dist_o, npd_o, acc_tot_o, rej_tot_o);
          end
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else if (out_valid && out_ready) begin
      rx_wait = $urandom_range(0, 9);
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; fix_drv = '0;
    m_threshold = mgr_pkg::THRESHOLD_RST; m_runs = mgr_pkg::RUNS_RST;
    m_armed = 1'b0; m_run = '0; m_acc = '0; m_rej = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_run_saturation();
    test_config_sweep();
    test_random();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- mahalanobis_gate_reacquire_top.f -----
rtl/mgr_pkg.sv
rtl/mgr_div.sv
rtl/mgr_sqrt.sv
rtl/mgr_datapath.sv
rtl/mgr_ctrl.sv
rtl/mahalanobis_gate_reacquire_top.sv
dv/tb_mahalanobis_gate_reacquire_top.sv
